FILE: sv/tensor_element_to_fp32_decoder_core_macros.svh
// assertion macros used by the decoder top level
`ifndef TENSOR_ELEMENT_TO_FP32_DECODER_CORE_MACROS_SVH
`define TENSOR_ELEMENT_TO_FP32_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TE2F_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("te2f check failed");

// next-cycle implication, disabled during reset
`define TE2F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("te2f check failed");

`endif

FILE: sv/te2f_pkg.sv
// types, constants and helpers of the tensor element decoder
package te2f_pkg;

    localparam int QUANT_BLOCK_ELEMENTS = 32;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        FMT_FP32  = 3'd0,
        FMT_FP16  = 3'd1,
        FMT_BF16  = 3'd2,
        FMT_INT8  = 3'd3,
        FMT_INT16 = 3'd4,
        FMT_INT32 = 3'd5,
        FMT_Q8_0  = 3'd6,
        FMT_Q4_0  = 3'd7
    } fmt_t;

    typedef enum logic [0:0] {
        REG_FORMAT = 1'b0,
        REG_COUNT  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        JOB_PASS = 2'd0,
        JOB_HALF = 2'd1,
        JOB_INT  = 2'd2,
        JOB_QMUL = 2'd3
    } job_kind_t;

    // one element waiting for conversion
    typedef struct packed {
        job_kind_t        kind;
        logic [31:0]      word;
        logic signed [7:0] q;
        logic             last;
    } job_t;

    // value = mag * 2^exp unless special
    typedef struct packed {
        logic              special;
        logic [31:0]       sp_bits;
        logic              sign;
        logic [31:0]       mag;
        logic signed [9:0] exp;
        logic              last;
    } prep_t;

    function automatic logic [5:0] group_length(input fmt_t fmt, input int blk);
        case (fmt)
            FMT_FP32:  group_length = 6'd4;
            FMT_FP16:  group_length = 6'd2;
            FMT_BF16:  group_length = 6'd2;
            FMT_INT8:  group_length = 6'd1;
            FMT_INT16: group_length = 6'd2;
            FMT_INT32: group_length = 6'd4;
            FMT_Q8_0:  group_length = 6'(4 + blk);
            default:   group_length = 6'(4 + blk / 2);
        endcase
    endfunction

endpackage

FILE: sv/te2f_ifs.sv
// valid/ready channel interfaces of the decoder
interface te2f_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_tensor;
    modport source (output valid, data_byte, start_of_tensor, input ready);
    modport sink (input valid, data_byte, start_of_tensor, output ready);
endinterface

interface te2f_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        last_element;
    modport source (output valid, value_bits, last_element, input ready);
    modport sink (input valid, value_bits, last_element, output ready);
endinterface

FILE: sv/te2f_round.sv
// normalize and round mag * 2^exp to binary32
module te2f_round (
    input  te2f_pkg::prep_t prep,
    output logic [31:0]     bits
);

    logic [31:0]        norm;
    logic [4:0]         lz;
    logic signed [10:0] be;
    logic signed [10:0] sub_amt;
    logic               inc;
    logic [30:0]        body;
    logic [31:0]        sub_k;

    always_comb
    begin
        norm = prep.mag;
        lz   = 5'd0;
        if (norm[31:16] == 16'd0)
        begin
            norm  = norm << 16;
            lz[4] = 1'b1;
        end
        if (norm[31:24] == 8'd0)
        begin
            norm  = norm << 8;
            lz[3] = 1'b1;
        end
        if (norm[31:28] == 4'd0)
        begin
            norm  = norm << 4;
            lz[2] = 1'b1;
        end
        if (norm[31:30] == 2'd0)
        begin
            norm  = norm << 2;
            lz[1] = 1'b1;
        end
        if (norm[31] == 1'b0)
        begin
            norm  = norm << 1;
            lz[0] = 1'b1;
        end
    end

    assign be      = 11'(prep.exp) + 11'sd158 - $signed({6'd0, lz});
    assign inc     = norm[7] & ((|norm[6:0]) | norm[8]);
    assign body    = {be[7:0], norm[30:8]} + 31'(inc);
    // below the normal range the product is an exact multiple of 2^-149
    assign sub_amt = 11'(prep.exp) + 11'sd149;
    assign sub_k   = prep.mag << sub_amt[4:0];

    always_comb
    begin
        if (prep.special)
            bits = prep.sp_bits;
        else if (prep.mag == 32'd0)
            bits = {prep.sign, 31'd0};
        else if (be >= 11'sd255)
            bits = {prep.sign, 8'hFF, 23'd0};
        else if (be >= 11'sd1)
            bits = {prep.sign, body};
        else
            bits = {prep.sign, 8'd0, sub_k[22:0]};
    end

endmodule

FILE: sv/tensor_element_to_fp32_decoder_core.sv
// top level: byte framing, element pipeline, result register, register port
//
//  channel   dir  payload                          transaction
//  in_ch     in   data_byte, start_of_tensor       one tensor byte
//  out_ch    out  value_bits, last_element         one binary32 element
//  apb       in   format (0x0), element count (0x4) register write/read
//
// one byte per cycle unless an output stall holds the pipeline or a second q4_0 element
// is pending: a q4_0 data byte that emits two elements blocks input until the single
// result lane after the byte framer takes its second; path: job, multiply, normalize/round
// every stage holds under output stall and refills as soon as it drains
// reset clears framing state, counters and valid bits; registers to defaults
`include "tensor_element_to_fp32_decoder_core_macros.svh"

module tensor_element_to_fp32_decoder_core #(
    parameter int QUANT_BLOCK_ELEMENTS = te2f_pkg::QUANT_BLOCK_ELEMENTS
) (
    input  logic        clk,
    input  logic        rst_n,
    te2f_in_if.sink     in_ch,
    te2f_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    te2f_pkg::fmt_t    fmt_reg;
    logic [31:0]       count_reg;
    logic [23:0]       partial_reg, partial_next;
    logic [5:0]        pos_reg, pos_next;
    logic [31:0]       scale_reg, scale_next;
    logic [31:0]       emitted_reg, emitted_next;

    te2f_pkg::job_t    pend_reg, s1_reg, job0, job1, job0_l, job1_l;
    logic              pend_v_reg, s1_v_reg;
    te2f_pkg::prep_t   s2_reg, prep;
    logic              s2_v_reg;
    logic [31:0]       out_bits_reg, rbits;
    logic              out_last_reg, out_v_reg;

    logic              e_out, e2, e1, accept, emit0, emit1;
    logic              has0, has1;
    logic [5:0]        glen, pos_raw, pos, pos_inc;
    logic [2:0]        wlen;
    logic [31:0]       cnt, cnt1, word;
    logic              cfg_wr;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == te2f_pkg::REG_COUNT) ? count_reg : {29'd0, fmt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= te2f_pkg::FMT_FP32;
            count_reg <= 32'd1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == te2f_pkg::REG_FORMAT)
                fmt_reg <= te2f_pkg::fmt_t'(pwdata[2:0]);
            else
                count_reg <= pwdata;
        end
    end

    // stage enables
    assign e_out       = !out_v_reg || out_ch.ready;
    assign e2          = !s2_v_reg || e_out;
    assign e1          = !s1_v_reg || e2;
    assign in_ch.ready = e1 && !pend_v_reg;
    assign accept      = in_ch.valid && in_ch.ready;

    // byte framing
    assign glen    = te2f_pkg::group_length(fmt_reg, QUANT_BLOCK_ELEMENTS);
    assign pos_raw = in_ch.start_of_tensor ? 6'd0 : pos_reg;
    assign pos     = (pos_raw >= glen) ? 6'd0 : pos_raw;
    assign pos_inc = pos + 6'd1;
    assign cnt     = in_ch.start_of_tensor ? 32'd0 : emitted_reg;
    assign wlen    = (fmt_reg == te2f_pkg::FMT_Q8_0 || fmt_reg == te2f_pkg::FMT_Q4_0)
                     ? 3'd4 : glen[2:0];

    always_comb
    begin
        case (pos[1:0])
            2'd0:    word = {24'd0, in_ch.data_byte};
            2'd1:    word = {16'd0, in_ch.data_byte, partial_reg[7:0]};
            2'd2:    word = {8'd0, in_ch.data_byte, partial_reg[15:0]};
            default: word = {in_ch.data_byte, partial_reg};
        endcase
    end

    always_comb
    begin
        partial_next = partial_reg;
        scale_next   = scale_reg;
        has0         = 1'b0;
        has1         = 1'b0;
        job0         = '0;
        job1         = '0;
        job0.word    = word;
        job1.word    = scale_reg;
        job1.kind    = te2f_pkg::JOB_QMUL;
        if ((fmt_reg == te2f_pkg::FMT_Q8_0 || fmt_reg == te2f_pkg::FMT_Q4_0)
            && pos >= 6'd4)
        begin
            has0      = 1'b1;
            job0.kind = te2f_pkg::JOB_QMUL;
            job0.word = scale_reg;
            if (fmt_reg == te2f_pkg::FMT_Q8_0)
                job0.q = $signed(in_ch.data_byte);
            else
            begin
                has1   = 1'b1;
                job0.q = $signed(8'(in_ch.data_byte[7:4]) - 8'd8);
                job1.q = $signed(8'(in_ch.data_byte[3:0]) - 8'd8);
            end
        end
        else if (pos_inc < {3'd0, wlen})
            partial_next = word[23:0];
        else
        begin
            has0 = 1'b1;
            case (fmt_reg)
                te2f_pkg::FMT_FP32:  job0.kind = te2f_pkg::JOB_PASS;
                te2f_pkg::FMT_FP16:  job0.kind = te2f_pkg::JOB_HALF;
                te2f_pkg::FMT_BF16:
                begin
                    job0.kind = te2f_pkg::JOB_PASS;
                    job0.word = {word[15:0], 16'd0};
                end
                te2f_pkg::FMT_INT8:
                begin
                    job0.kind = te2f_pkg::JOB_INT;
                    job0.word = {{24{word[7]}}, word[7:0]};
                end
                te2f_pkg::FMT_INT16:
                begin
                    job0.kind = te2f_pkg::JOB_INT;
                    job0.word = {{16{word[15]}}, word[15:0]};
                end
                te2f_pkg::FMT_INT32: job0.kind = te2f_pkg::JOB_INT;
                default:
                begin
                    has0       = 1'b0;
                    scale_next = word;
                end
            endcase
        end
    end

    assign emit0        = has0 && (cnt < count_reg);
    assign cnt1         = cnt + 32'(emit0);
    assign emit1        = has1 && (cnt1 < count_reg);
    assign emitted_next = cnt1 + 32'(emit1);
    assign pos_next     = (pos_inc >= glen) ? 6'd0 : pos_inc;

    // last flags follow the count at the time the byte is taken
    always_comb
    begin
        job0_l      = job0;
        job0_l.last = (cnt + 32'd1) == count_reg;
        job1_l      = job1;
        job1_l.last = (cnt1 + 32'd1) == count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pos_reg     <= '0;
            scale_reg   <= '0;
            emitted_reg <= '0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            pos_reg     <= pos_next;
            scale_reg   <= scale_next;
            emitted_reg <= emitted_next;
        end
    end

    // pending second q4_0 element and job stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            s1_v_reg   <= 1'b0;
        end
        else if (e1)
        begin
            pend_v_reg <= accept && emit1;
            s1_v_reg   <= pend_v_reg || (accept && emit0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (e1)
        begin
            if (pend_v_reg)
                s1_reg <= pend_reg;
            else
                s1_reg <= job0_l;
            pend_reg <= job1_l;
        end
    end

    // unpack and multiply
    logic [7:0]  q_abs;
    logic [23:0] sig;
    logic [7:0]  se;
    logic [4:0]  hex;

    assign q_abs = s1_reg.q[7] ? 8'(-s1_reg.q) : 8'(s1_reg.q);
    assign se    = s1_reg.word[30:23];
    assign sig   = {se != 8'd0, s1_reg.word[22:0]};
    assign hex   = s1_reg.word[14:10];

    always_comb
    begin
        prep         = '0;
        prep.last    = s1_reg.last;
        case (s1_reg.kind)
            te2f_pkg::JOB_PASS:
            begin
                prep.special = 1'b1;
                prep.sp_bits = s1_reg.word;
            end
            te2f_pkg::JOB_HALF:
            begin
                prep.sign = s1_reg.word[15];
                if (hex == 5'h1F)
                begin
                    prep.special = 1'b1;
                    prep.sp_bits = (s1_reg.word[9:0] != 10'd0) ? te2f_pkg::CANON_NAN
                                   : {s1_reg.word[15], 8'hFF, 23'd0};
                end
                else if (hex == 5'd0)
                begin
                    prep.mag = {22'd0, s1_reg.word[9:0]};
                    prep.exp = -10'sd24;
                end
                else
                begin
                    prep.mag = {21'd0, 1'b1, s1_reg.word[9:0]};
                    prep.exp = $signed({5'd0, hex}) - 10'sd25;
                end
            end
            te2f_pkg::JOB_INT:
            begin
                prep.sign = s1_reg.word[31];
                prep.mag  = s1_reg.word[31] ? (~s1_reg.word + 32'd1) : s1_reg.word;
            end
            default:
            begin
                prep.sign = s1_reg.word[31] ^ s1_reg.q[7];
                if (se == 8'hFF)
                begin
                    prep.special = 1'b1;
                    prep.sp_bits = (s1_reg.word[22:0] != 23'd0 || s1_reg.q == 8'sd0)
                                   ? te2f_pkg::CANON_NAN : {prep.sign, 8'hFF, 23'd0};
                end
                else
                begin
                    prep.mag = 32'(sig * q_abs);
                    prep.exp = $signed({2'd0, (se == 8'd0) ? 8'd1 : se}) - 10'sd150;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (e2)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (e2)
            s2_reg <= prep;
    end

    te2f_round u_round (
        .prep (s2_reg),
        .bits (rbits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (e_out)
            out_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (e_out)
        begin
            out_bits_reg <= rbits;
            out_last_reg <= s2_reg.last;
        end
    end

    assign out_ch.valid        = out_v_reg;
    assign out_ch.value_bits   = out_bits_reg;
    assign out_ch.last_element = out_last_reg;

    `TE2F_ASSERT_NEXT(a_pend_after_pair, clk, rst_n, accept && emit1, pend_v_reg)
    `TE2F_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_v_reg && !e2, s1_v_reg && $stable(s1_reg))
    `TE2F_ASSERT_NOW(a_no_accept_pend, clk, rst_n, pend_v_reg, !accept)
    `TE2F_ASSERT_NOW(a_zero_mag, clk, rst_n,
        s2_v_reg && !s2_reg.special && s2_reg.mag == 32'd0, rbits[30:0] == 31'd0)

endmodule
